// ===== rtl/assert_macros.svh =====
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, switched off while reset is high
`define BBD_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("bbd check failed");

// clocked check that also holds through reset
`define BBD_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("bbd check failed");

`endif

// ===== rtl/bbd_pkg.sv =====
`timescale 1ns / 1ps
// types and constants of the bilinear bayer demosaic block
// no dependencies
package bbd_pkg;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_FRAME_WIDTH   = 2'd0,
    CFG_FRAME_HEIGHT  = 2'd1,
    CFG_BAYER_PATTERN = 2'd2,
    CFG_SAMPLE_DEPTH  = 2'd3
  } cfg_reg_t;

  // colour site of the window center
  typedef enum logic [1:0] {
    SITE_RED,
    SITE_BLUE,
    SITE_GREEN_RROW,
    SITE_GREEN_BROW
  } site_t;

  // one result beat
  typedef struct packed {
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
    logic [11:0] pixel_row;
    logic [11:0] pixel_col;
    logic        frame_last;
  } out_beat_t;

  localparam logic [11:0] POS_LAST     = 12'd4095;
  localparam int          POS_SPAN     = 4096;
  localparam logic [12:0] SIZE_MIN     = 13'd3;
  localparam logic [12:0] SIZE_MAX     = 13'd4096;
  localparam logic [12:0] WIDTH_RESET  = 13'd640;
  localparam logic [12:0] HEIGHT_RESET = 13'd480;

  // row parity of the red site: RGGB, BGGR, GRBG, GBRG
  function automatic logic red_row(input logic [1:0] pattern);
    unique case (pattern)
      2'd0:    return 1'b0;
      2'd1:    return 1'b1;
      2'd2:    return 1'b0;
      default: return 1'b1;
    endcase
  endfunction

  // column parity of the red site
  function automatic logic red_col(input logic [1:0] pattern);
    unique case (pattern)
      2'd0:    return 1'b0;
      2'd1:    return 1'b1;
      2'd2:    return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

endpackage

// ===== rtl/bbd_pix_if.sv =====
`timescale 1ns / 1ps
// stream channel carrying raw mosaic samples
// no dependencies
interface bbd_pix_if;
  logic        valid;
  logic        ready;
  logic [15:0] pixel_value;
  logic        frame_start;

  modport source (output valid, pixel_value, frame_start, input ready);
  modport sink   (input valid, pixel_value, frame_start, output ready);
endinterface

// ===== rtl/bbd_rgb_if.sv =====
`timescale 1ns / 1ps
// stream channel carrying demosaiced rgb pixels
// no dependencies
interface bbd_rgb_if;
  logic        valid;
  logic        ready;
  logic [15:0] red;
  logic [15:0] green;
  logic [15:0] blue;
  logic [11:0] pixel_row;
  logic [11:0] pixel_col;
  logic        frame_last;

  modport source (output valid, red, green, blue, pixel_row, pixel_col, frame_last,
                  input ready);
  modport sink   (input valid, red, green, blue, pixel_row, pixel_col, frame_last,
                  output ready);
endinterface

// ===== rtl/bbd_cfg_if.sv =====
`timescale 1ns / 1ps
// register write channel
// no dependencies
interface bbd_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [12:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/bbd_ram.sv =====
`timescale 1ns / 1ps
// generic single-write, single-read ram with registered read data
// read returns the old contents when read and write hit the same address
module bbd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/bilinear_bayer_demosaic.sv =====
`timescale 1ns / 1ps
// bilinear bayer demosaic: raw mosaic stream in, rgb stream out
// depends on bbd_pkg, bbd_pix_if, bbd_rgb_if, bbd_cfg_if, bbd_ram
//
// Usage
//   cfg     : register writes (index, data); always ready outside reset. Write
//             only while the block is idle.
//   pix_in  : one raw sample per beat in raster order; frame_start marks row 0,
//             column 0. Frames also wrap after the last sample by count.
//   rgb_out : one beat per interior pixel (rows and columns 1..size-2), with
//             its row, column and a frame_last flag on the final pixel.
// The result for pixel (r,c) is formed once the input beat of pixel (r+1,c+1)
//   is taken; it passes the stage one registers and then the output queue.
// Throughput: one sample per cycle while pix_in.ready is high; the line store ram
//   is read in the accept cycle and written back in the next cycle, with a bypass
//   for back-to-back beats at the same column.
// Reset clears counters, window, valid flags and output queue; the line store is
//   not cleared (only rows already written in a frame reach a result).
// A four-entry output queue absorbs stalls; pix_in.ready drops once the queued
//   beats and the stage in flight reach three, so at most three are queued.
module bilinear_bayer_demosaic import bbd_pkg::*; #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic       clk,
  input  logic       rst,
  bbd_cfg_if.sink    cfg,
  bbd_pix_if.sink    pix_in,
  bbd_rgb_if.source  rgb_out
);

  localparam int RAM_DEPTH = (MAX_WIDTH < POS_SPAN) ? MAX_WIDTH : POS_SPAN;
  localparam int AW        = $clog2(RAM_DEPTH);

  // configuration registers
  logic [12:0] frame_width;
  logic [12:0] frame_height;
  logic [1:0]  bayer_pattern;
  logic        sample_depth;

  // position of the next sample
  logic [11:0] row_count;
  logic [11:0] col_count;

  // stage one registers
  logic          s1_valid;
  logic [15:0]   s1_pix;
  logic [AW-1:0] s1_addr;
  logic          s1_addr_ok;
  logic          s1_emit;
  logic [11:0]   s1_row;
  logic [11:0]   s1_col;
  logic          s1_last;
  site_t         s1_site;
  logic          fwd_hit;
  logic [31:0]   fwd_data;

  // window: columns c-2 (0..2) and c-1 (3..5), rows top to bottom
  logic [15:0] win [6];

  // output queue
  out_beat_t fifo_mem [4];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] count;

  logic        in_accept;
  logic        out_accept;
  logic [31:0] ram_rdata;

  function automatic logic size_ok(input logic [12:0] v, input int maxv);
    return (v >= SIZE_MIN) && (v <= SIZE_MAX) && (int'(v) <= maxv);
  endfunction

  // configuration writes
  assign cfg.ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width   <= WIDTH_RESET;
      frame_height  <= HEIGHT_RESET;
      bayer_pattern <= 2'd0;
      sample_depth  <= 1'b0;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg_reg_t'(cfg.index))
        CFG_FRAME_WIDTH:   frame_width   <= cfg.data;
        CFG_FRAME_HEIGHT:  frame_height  <= cfg.data;
        CFG_BAYER_PATTERN: bayer_pattern <= cfg.data[1:0];
        CFG_SAMPLE_DEPTH:  sample_depth  <= cfg.data[0];
      endcase
    end
  end

  // input handshake: keep room for the queue and the beat in flight
  assign pix_in.ready = !rst && ((count + {2'b00, s1_valid}) < 3'd3);
  assign in_accept    = pix_in.valid && pix_in.ready;

  // stage zero: position, read address, result decision
  logic [11:0]   cur_row;
  logic [11:0]   cur_col;
  logic [15:0]   pix_m;
  logic          col_end;
  logic          row_end;
  logic          addr_ok;
  logic [AW-1:0] addr;
  logic          emit;
  logic [11:0]   pos_y;
  logic [11:0]   pos_x;
  logic          last;
  site_t         site;

  always_comb begin
    cur_row = pix_in.frame_start ? 12'd0 : row_count;
    cur_col = pix_in.frame_start ? 12'd0 : col_count;
    pix_m   = sample_depth ? pix_in.pixel_value : {8'h00, pix_in.pixel_value[7:0]};
    col_end = (({1'b0, cur_col} + 13'd1) >= frame_width) || (cur_col == POS_LAST);
    row_end = (({1'b0, cur_row} + 13'd1) >= frame_height) || (cur_row == POS_LAST);
    addr_ok = int'(cur_col) < RAM_DEPTH;
    addr    = cur_col[AW-1:0];
    emit    = size_ok(frame_width, MAX_WIDTH) && size_ok(frame_height, MAX_HEIGHT) &&
              (cur_row >= 12'd2) && (cur_col >= 12'd2) &&
              ({1'b0, cur_row} < frame_height) && ({1'b0, cur_col} < frame_width);
    pos_y   = cur_row - 12'd1;
    pos_x   = cur_col - 12'd1;
    last    = ({1'b0, pos_y} == (frame_height - 13'd2)) &&
              ({1'b0, pos_x} == (frame_width - 13'd2));
    unique case ({pos_y[0] == red_row(bayer_pattern), pos_x[0] == red_col(bayer_pattern)})
      2'b11:   site = SITE_RED;
      2'b00:   site = SITE_BLUE;
      2'b10:   site = SITE_GREEN_RROW;
      default: site = SITE_GREEN_BROW;
    endcase
  end

  // position counters
  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= 12'd0;
      col_count <= 12'd0;
    end else if (in_accept) begin
      if (col_end) begin
        col_count <= 12'd0;
        row_count <= row_end ? 12'd0 : cur_row + 12'd1;
      end else begin
        col_count <= cur_col + 12'd1;
        row_count <= cur_row;
      end
    end
  end

  // stage one: line store data, bypass, window and averages
  logic [15:0] up_eff;
  logic [15:0] mid_eff;
  logic [17:0] cross_sum;
  logic [17:0] diag_sum;
  logic [16:0] horiz_sum;
  logic [16:0] vert_sum;
  logic [15:0] cross_avg;
  logic [15:0] diag_avg;
  logic [15:0] horiz_avg;
  logic [15:0] vert_avg;
  out_beat_t   beat;
  logic        ram_we;
  logic [31:0] ram_wdata;

  always_comb begin
    if (!s1_addr_ok) begin
      up_eff  = 16'd0;
      mid_eff = 16'd0;
    end else if (fwd_hit) begin
      up_eff  = fwd_data[31:16];
      mid_eff = fwd_data[15:0];
    end else begin
      up_eff  = ram_rdata[31:16];
      mid_eff = ram_rdata[15:0];
    end
    ram_we    = s1_valid && s1_addr_ok;
    ram_wdata = {mid_eff, s1_pix};

    cross_sum = {2'b00, win[3]} + {2'b00, win[1]} + {2'b00, mid_eff} + {2'b00, win[5]};
    diag_sum  = {2'b00, win[0]} + {2'b00, up_eff} + {2'b00, win[2]} + {2'b00, s1_pix};
    horiz_sum = {1'b0, win[1]} + {1'b0, mid_eff};
    vert_sum  = {1'b0, win[3]} + {1'b0, win[5]};
    cross_avg = cross_sum[17:2];
    diag_avg  = diag_sum[17:2];
    horiz_avg = horiz_sum[16:1];
    vert_avg  = vert_sum[16:1];

    beat.pixel_row  = s1_row;
    beat.pixel_col  = s1_col;
    beat.frame_last = s1_last;
    unique case (s1_site)
      SITE_RED: begin
        beat.red   = win[4];
        beat.green = cross_avg;
        beat.blue  = diag_avg;
      end
      SITE_BLUE: begin
        beat.red   = diag_avg;
        beat.green = cross_avg;
        beat.blue  = win[4];
      end
      SITE_GREEN_RROW: begin
        beat.red   = horiz_avg;
        beat.green = win[4];
        beat.blue  = vert_avg;
      end
      SITE_GREEN_BROW: begin
        beat.red   = vert_avg;
        beat.green = win[4];
        beat.blue  = horiz_avg;
      end
    endcase
  end

  // line store: upper row in the high half, middle row in the low half
  bbd_ram #(
    .WIDTH (32),
    .DEPTH (RAM_DEPTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s1_addr),
    .wdata (ram_wdata),
    .re    (in_accept),
    .raddr (addr),
    .rdata (ram_rdata)
  );

  // stage one valid and bypass control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      fwd_hit  <= 1'b0;
    end else begin
      s1_valid <= in_accept;
      fwd_hit  <= in_accept && ram_we && addr_ok && (addr == s1_addr);
    end
  end

  // stage one payload
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_pix     <= pix_m;
      s1_addr    <= addr;
      s1_addr_ok <= addr_ok;
      s1_emit    <= emit;
      s1_row     <= pos_y;
      s1_col     <= pos_x;
      s1_last    <= last;
      s1_site    <= site;
      fwd_data   <= ram_wdata;
    end
  end

  // window shift
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) begin
        win[i] <= 16'd0;
      end
    end else if (s1_valid) begin
      win[0] <= win[3];
      win[1] <= win[4];
      win[2] <= win[5];
      win[3] <= up_eff;
      win[4] <= mid_eff;
      win[5] <= s1_pix;
    end
  end

  // output queue
  logic push;

  assign push       = s1_valid && s1_emit;
  assign out_accept = rgb_out.valid && rgb_out.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 2'd0;
      rd_ptr <= 2'd0;
      count  <= 3'd0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 2'd1;
      end
      if (out_accept) begin
        rd_ptr <= rd_ptr + 2'd1;
      end
      count <= count + {2'b00, push} - {2'b00, out_accept};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_mem[wr_ptr] <= beat;
    end
  end

  // output beat
  assign rgb_out.valid      = count != 3'd0;
  assign rgb_out.red        = fifo_mem[rd_ptr].red;
  assign rgb_out.green      = fifo_mem[rd_ptr].green;
  assign rgb_out.blue       = fifo_mem[rd_ptr].blue;
  assign rgb_out.pixel_row  = fifo_mem[rd_ptr].pixel_row;
  assign rgb_out.pixel_col  = fifo_mem[rd_ptr].pixel_col;
  assign rgb_out.frame_last = fifo_mem[rd_ptr].frame_last;

endmodule

// ===== rtl/bbd_checker.sv =====
`timescale 1ns / 1ps
// port-level checks for the bilinear bayer demosaic top level
// depends on assert_macros.svh; bound to bilinear_bayer_demosaic below
`include "assert_macros.svh"

module bbd_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [11:0] out_row,
  input logic [11:0] out_col
);

  // interior bounds of a reported position
  logic row_inner;
  logic col_inner;

  assign row_inner = (out_row != 12'd0) && (out_row != 12'd4095);
  assign col_inner = (out_col != 12'd0) && (out_col != 12'd4095);

  // a stalled output beat stays offered
  `BBD_ASSERT(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid)

  // reset empties the output queue
  `BBD_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !out_valid)

  // input back-pressure only while results are waiting
  `BBD_ASSERT(a_ready_low, clk, rst, !in_ready |-> out_valid)

  // only interior positions are reported
  `BBD_ASSERT(a_interior, clk, rst, out_valid |-> row_inner && col_inner)

endmodule

bind bilinear_bayer_demosaic bbd_checker u_bbd_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (pix_in.ready),
  .out_valid (rgb_out.valid),
  .out_ready (rgb_out.ready),
  .out_row   (rgb_out.pixel_row),
  .out_col   (rgb_out.pixel_col)
);
